FILE: design/pixel_format_converter_defines.svh
// ----------------------------------------------------------------------------
// pixel format converter assertion macros
// shared concurrent check forms, clocked on clk and held off during reset
// ----------------------------------------------------------------------------
`ifndef PIXEL_FORMAT_CONVERTER_DEFINES_SVH
`define PIXEL_FORMAT_CONVERTER_DEFINES_SVH

// same-cycle implication
`define PFC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PFC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/pfc_pkg.sv
// ----------------------------------------------------------------------------
// pfc_pkg
// formats, register indexes and the queue word shared by the converter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pfc_pkg;

    typedef enum logic [1:0] {
        FMT_RGBA = 2'd0,
        FMT_RGB  = 2'd1,
        FMT_A8   = 2'd2,
        FMT_565  = 2'd3
    } pfc_fmt_t;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_FORMAT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PREMULTIPLY   = 2'd2;

    // target code meaning "same as source"
    localparam logic [2:0] TGT_SAME = 3'd4;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

    localparam int unsigned QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        pfc_fmt_t   dst;
        logic       premul;
        logic       eor;
        logic       transl;
    } pfc_word_t;

endpackage

`default_nettype wire

FILE: design/pixel_format_converter.sv
// ----------------------------------------------------------------------------
// pixel_format_converter
// converts rgba8888, rgb888 or alpha8 pixels to rgba8888, rgb888, alpha8 or
// rgb565, with optional alpha premultiply and per-row translucency flag
// ----------------------------------------------------------------------------
// input side: drive a pixel word and raise push; it is taken on an edge where
// full is low. unsupported format pairs are taken and dropped silently.
// result side: while empty is low the oldest result word is on the ports;
// raise pop to take it.
// config: cfg_write with cfg_index/cfg_data, only while the block is idle.
// path: a taken word is written into the queue, then into the product register,
// then into the result register, where it is visible with empty low.
// throughput: one word per clock sustained while pop is held; the three
// 8x8 channel multipliers in the back end each take one product per cycle.
// when the receiver stalls the result register holds, the product stage and
// then the queue fill, and full rises once the queue holds QueueDepth words.
// reset: format registers return to rgba8888 source / same-as-source target,
// premultiply off, the row alpha accumulator to opaque, queue and pipe empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "pixel_format_converter_defines.svh"

module pixel_format_converter
    import pfc_pkg::*;
#(
    parameter int unsigned QueueDepth = QUEUE_DEPTH
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [7:0]            in_red,
    input  wire logic [7:0]            in_green,
    input  wire logic [7:0]            in_blue,
    input  wire logic [7:0]            in_alpha,
    input  wire logic                  end_of_row,
    output logic                       empty,
    input  wire logic                  pop,
    output logic [7:0]                 out_red,
    output logic [7:0]                 out_green,
    output logic [7:0]                 out_blue,
    output logic [7:0]                 out_alpha,
    output logic [15:0]                out_rgb565,
    output logic                       row_translucent,
    output logic                       last_of_row
);

    logic      q_push;
    logic      q_full;
    logic      q_pop;
    logic      q_empty;
    pfc_word_t q_wr_word;
    pfc_word_t q_rd_word;

    assign full = q_full;

    pfc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .in_red     (in_red),
        .in_green   (in_green),
        .in_blue    (in_blue),
        .in_alpha   (in_alpha),
        .end_of_row (end_of_row),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_word     (q_wr_word)
    );

    pfc_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_word (q_wr_word),
        .full    (q_full),
        .rd_en   (q_pop),
        .empty   (q_empty),
        .rd_word (q_rd_word)
    );

    pfc_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_empty         (q_empty),
        .q_word          (q_rd_word),
        .q_pop           (q_pop),
        .pop             (pop),
        .empty           (empty),
        .out_red         (out_red),
        .out_green       (out_green),
        .out_blue        (out_blue),
        .out_alpha       (out_alpha),
        .out_rgb565      (out_rgb565),
        .row_translucent (row_translucent),
        .last_of_row     (last_of_row)
    );

    `PFC_ASSERT_NOW(a_no_push_when_full, q_push, !q_full, "queue written while full")
    `PFC_ASSERT_NOW(a_transl_at_row_end, !empty && row_translucent, last_of_row,
        "translucency flagged away from row end")
    `PFC_ASSERT_NOW(a_rgb565_exclusive, !empty && (out_rgb565 != 16'h0000),
        (out_red == 8'h00) && (out_alpha == 8'h00), "rgb565 word mixed with byte channels")
    `PFC_ASSERT_NEXT(a_queue_fills_on_stall, q_full && !q_pop, q_full,
        "queue lost a word while stalled")

endmodule

`default_nettype wire

FILE: design/pfc_front.sv
// ----------------------------------------------------------------------------
// pfc_front
// configuration registers, pixel classification and row alpha tracking
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfc_front
    import pfc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  push,
    input  wire logic [7:0]            in_red,
    input  wire logic [7:0]            in_green,
    input  wire logic [7:0]            in_blue,
    input  wire logic [7:0]            in_alpha,
    input  wire logic                  end_of_row,
    input  wire logic                  q_full,
    output logic                       q_push,
    output pfc_word_t                  q_word
);

    pfc_fmt_t   src_reg;
    logic [2:0] tgt_reg;
    logic       pm_en_reg;
    logic [7:0] acc_reg;
    logic [7:0] acc_next;

    logic [2:0] dst_code;
    pfc_fmt_t   dst;
    logic       supported;
    logic       accept;
    logic       tracks;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       premul;
    logic [7:0] acc_and;

    always_comb
    begin
        dst_code  = (tgt_reg == TGT_SAME) ? {1'b0, src_reg} : tgt_reg;
        dst       = pfc_fmt_t'(dst_code[1:0]);
        supported = (src_reg != FMT_565) && !dst_code[2];
        accept    = push && !q_full;

        if (src_reg == FMT_A8)
        begin
            red   = ALPHA_OPAQUE;
            green = ALPHA_OPAQUE;
            blue  = ALPHA_OPAQUE;
            alpha = in_alpha;
        end
        else
        begin
            red   = in_red;
            green = in_green;
            blue  = in_blue;
            alpha = (src_reg == FMT_RGB) ? ALPHA_OPAQUE : in_alpha;
        end

        tracks = (src_reg != FMT_RGB) && ((dst == FMT_RGBA) || (dst == FMT_A8));

        case (dst)
            FMT_RGBA: premul = pm_en_reg;
            FMT_A8:   premul = 1'b0;
            default:  premul = (src_reg != FMT_RGB);
        endcase

        acc_and  = tracks ? (acc_reg & alpha) : acc_reg;
        acc_next = acc_reg;
        if (accept && supported)
        begin
            acc_next = end_of_row ? ALPHA_OPAQUE : acc_and;
        end

        q_push        = accept && supported;
        q_word.red    = red;
        q_word.green  = green;
        q_word.blue   = blue;
        q_word.alpha  = alpha;
        q_word.dst    = dst;
        q_word.premul = premul;
        q_word.eor    = end_of_row;
        q_word.transl = end_of_row && tracks && (acc_and != ALPHA_OPAQUE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg   <= FMT_RGBA;
            tgt_reg   <= TGT_SAME;
            pm_en_reg <= 1'b0;
            acc_reg   <= ALPHA_OPAQUE;
        end
        else
        begin
            acc_reg <= acc_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_SOURCE_FORMAT: src_reg   <= pfc_fmt_t'(cfg_data[1:0]);
                    REG_TARGET_FORMAT: tgt_reg   <= cfg_data;
                    REG_PREMULTIPLY:   pm_en_reg <= cfg_data[0];
                    default:           ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/pfc_queue.sv
// ----------------------------------------------------------------------------
// pfc_queue
// short word queue between the front and the back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfc_queue
    import pfc_pkg::*;
#(
    parameter int unsigned Depth = QUEUE_DEPTH
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      wr_en,
    input  wire pfc_word_t wr_word,
    output logic           full,
    input  wire logic      rd_en,
    output logic           empty,
    output pfc_word_t      rd_word
);

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);

    pfc_word_t           entry_reg [Depth];
    logic [PtrW-1:0]     wr_ptr_reg;
    logic [PtrW-1:0]     rd_ptr_reg;
    logic [CntW-1:0]     count_reg;
    logic                do_wr;
    logic                do_rd;

    assign full    = (count_reg == CntW'(Depth));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_word = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/pfc_back.sv
// ----------------------------------------------------------------------------
// pfc_back
// premultiply, channel selection and rgb565 packing into the result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfc_back
    import pfc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       q_empty,
    input  wire pfc_word_t  q_word,
    output logic            q_pop,
    input  wire logic       pop,
    output logic            empty,
    output logic [7:0]      out_red,
    output logic [7:0]      out_green,
    output logic [7:0]      out_blue,
    output logic [7:0]      out_alpha,
    output logic [15:0]     out_rgb565,
    output logic            row_translucent,
    output logic            last_of_row
);

    // rounded x*a/255 from the registered product
    function automatic logic [7:0] round_div255(input logic [15:0] prod);
        logic [15:0] p;
        logic [15:0] t;
        begin
            p = prod + 16'd128;
            t = p + {8'h00, p[15:8]};
            return t[15:8];
        end
    endfunction

    // product stage
    logic        s1_valid_reg;
    pfc_word_t   s1_word_reg;
    logic [15:0] s1_red_prod_reg;
    logic [15:0] s1_green_prod_reg;
    logic [15:0] s1_blue_prod_reg;

    // result register
    logic        out_valid_reg;
    logic [7:0]  out_red_reg;
    logic [7:0]  out_green_reg;
    logic [7:0]  out_blue_reg;
    logic [7:0]  out_alpha_reg;
    logic [15:0] out_rgb565_reg;
    logic        out_transl_reg;
    logic        out_eor_reg;

    logic        out_take;
    logic        s1_move;
    logic        s1_take;

    logic [7:0]  red_next;
    logic [7:0]  green_next;
    logic [7:0]  blue_next;
    logic [7:0]  col_red;
    logic [7:0]  col_green;
    logic [7:0]  col_blue;
    logic [7:0]  alpha_next;
    logic [15:0] rgb565_next;

    assign out_take = !out_valid_reg || pop;
    assign s1_move  = s1_valid_reg && out_take;
    assign s1_take  = !s1_valid_reg || s1_move;
    assign q_pop    = !q_empty && s1_take;

    always_comb
    begin
        if (s1_word_reg.premul)
        begin
            col_red   = round_div255(s1_red_prod_reg);
            col_green = round_div255(s1_green_prod_reg);
            col_blue  = round_div255(s1_blue_prod_reg);
        end
        else
        begin
            col_red   = s1_word_reg.red;
            col_green = s1_word_reg.green;
            col_blue  = s1_word_reg.blue;
        end

        red_next    = '0;
        green_next  = '0;
        blue_next   = '0;
        alpha_next  = '0;
        rgb565_next = '0;
        unique case (s1_word_reg.dst)
            FMT_RGBA:
            begin
                red_next   = col_red;
                green_next = col_green;
                blue_next  = col_blue;
                alpha_next = s1_word_reg.alpha;
            end
            FMT_RGB:
            begin
                red_next   = col_red;
                green_next = col_green;
                blue_next  = col_blue;
            end
            FMT_A8:
            begin
                alpha_next = s1_word_reg.alpha;
            end
            FMT_565:
            begin
                rgb565_next = {col_red[7:3], col_green[7:2], col_blue[7:3]};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_word_reg       <= q_word;
            s1_red_prod_reg   <= 16'(q_word.red) * 16'(q_word.alpha);
            s1_green_prod_reg <= 16'(q_word.green) * 16'(q_word.alpha);
            s1_blue_prod_reg  <= 16'(q_word.blue) * 16'(q_word.alpha);
        end
        if (s1_move)
        begin
            out_red_reg    <= red_next;
            out_green_reg  <= green_next;
            out_blue_reg   <= blue_next;
            out_alpha_reg  <= alpha_next;
            out_rgb565_reg <= rgb565_next;
            out_transl_reg <= s1_word_reg.transl;
            out_eor_reg    <= s1_word_reg.eor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_take)
            begin
                s1_valid_reg <= q_pop;
            end
            if (out_take)
            begin
                out_valid_reg <= s1_move;
            end
        end
    end

    assign empty           = !out_valid_reg;
    assign out_red         = out_red_reg;
    assign out_green       = out_green_reg;
    assign out_blue        = out_blue_reg;
    assign out_alpha       = out_alpha_reg;
    assign out_rgb565      = out_rgb565_reg;
    assign row_translucent = out_transl_reg;
    assign last_of_row     = out_eor_reg;

endmodule

`default_nettype wire
